[rtl/tsync_pkg.sv]
// Shared types and constants for the three-channel synchronized timer.
package tsync_pkg;

    // Item commands.
    typedef enum logic [2:0] {
        CMD_CPU_CYCLES   = 3'd0,
        CMD_DOTS         = 3'd1,
        CMD_HBLANK_START = 3'd2,
        CMD_HBLANK_END   = 3'd3,
        CMD_VBLANK_START = 3'd4,
        CMD_VBLANK_END   = 3'd5,
        CMD_WRITE        = 3'd6,
        CMD_READ         = 3'd7
    } t_cmd;

    // Register offsets within one counter.
    localparam logic [3:0] OFF_COUNT  = 4'd0;
    localparam logic [3:0] OFF_MODE   = 4'd4;
    localparam logic [3:0] OFF_TARGET = 4'd8;

    // Highest valid counter index.
    localparam logic [1:0] LAST_TIMER = 2'd2;
    localparam int         NumTimers  = 3;

    // Mode register bit positions.
    localparam int MB_SYNC_EN   = 0;
    localparam int MB_SYNC_LO   = 1;
    localparam int MB_SYNC_HI   = 2;
    localparam int MB_ON_TARGET = 3;
    localparam int MB_IRQ_EN    = 4;
    localparam int MB_REPEAT    = 6;
    localparam int MB_TOGGLE    = 7;
    localparam int MB_SRC       = 8;
    localparam int MB_DIV8      = 9;
    localparam int MB_IRQ_LINE  = 10;
    localparam int MB_HIT_TGT   = 11;
    localparam int MB_HIT_MAX   = 12;

    // Sync modes from the two sync bits.
    localparam logic [1:0] SYNC_M0 = 2'd0;
    localparam logic [1:0] SYNC_M1 = 2'd1;
    localparam logic [1:0] SYNC_M2 = 2'd2;
    localparam logic [1:0] SYNC_M3 = 2'd3;

    localparam logic [9:0]  MODE_WRITE_MASK = 10'h3FF;
    localparam logic [17:0] WRAP_LIMIT      = 18'h0FFFF;

    // Per-counter state that changes as the counter advances.
    typedef struct packed {
        logic [12:0] mode;
        logic [16:0] count;
        logic        pend;
        logic        fired;
    } t_chan_st;

endpackage

[rtl/tsync_chan.sv]
// One counter advance step: increment, wrap check and interrupt raise.
module tsync_chan
    import tsync_pkg::*;
(
    input  logic        i_en,
    input  logic        i_run,
    input  logic [16:0] i_inc,
    input  logic [15:0] i_target,
    input  t_chan_st    i_st,
    output t_chan_st    o_st,
    output logic        o_irq
);

    always_comb begin
        t_chan_st    st;
        logic [17:0] sum;
        logic        hit;

        st    = i_st;
        o_irq = 1'b0;
        sum   = '0;
        hit   = 1'b0;
        if (i_en) begin
            // A pending pulse releases the interrupt line first.
            if (st.pend) begin
                st.mode[MB_IRQ_LINE] = 1'b1;
                st.pend              = 1'b0;
            end

            // Count forward when the sync mode lets the counter run.
            sum = {1'b0, st.count};
            if (i_run) begin
                sum = {1'b0, st.count} + {1'b0, i_inc};
            end

            // Wrap at the target or at the full-scale value.
            if (st.mode[MB_ON_TARGET]) begin
                hit = (sum >= {2'b00, i_target});
            end else begin
                hit = (sum >= WRAP_LIMIT);
            end

            if (hit) begin
                st.count = '0;
                if (st.mode[MB_ON_TARGET]) begin
                    st.mode[MB_HIT_TGT] = 1'b1;
                end else begin
                    st.mode[MB_HIT_MAX] = 1'b1;
                end
                // Raise the interrupt in pulse or toggle form.
                if (st.mode[MB_IRQ_EN]) begin
                    if (st.mode[MB_TOGGLE]) begin
                        if ((st.mode[MB_REPEAT] || !st.fired) && st.mode[MB_IRQ_LINE]) begin
                            st.mode[MB_IRQ_LINE] = 1'b0;
                            st.fired             = 1'b1;
                            o_irq                = 1'b1;
                        end else if (st.mode[MB_REPEAT] && st.fired) begin
                            st.mode[MB_IRQ_LINE] = 1'b1;
                        end
                    end else if (st.mode[MB_IRQ_LINE]) begin
                        st.mode[MB_IRQ_LINE] = 1'b0;
                        st.pend              = 1'b1;
                        o_irq                = 1'b1;
                    end
                end
            end else begin
                st.count = sum[16:0];
            end
        end
        o_st = st;
    end

endmodule

[rtl/tsync_state.sv]
// Timer state registers and the per-beat update of all three counters.
module tsync_state
    import tsync_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_amount,
    input  logic [1:0]  i_timer_index,
    input  logic [3:0]  i_reg_offset,
    input  logic [15:0] i_write_data,
    output logic [15:0] o_read_data,
    output logic [2:0]  o_irq_mask
);

    t_chan_st    r_ch  [NumTimers];
    logic [15:0] r_tgt [NumTimers];
    logic [2:0]  r_rem;
    logic [1:0]  r_start;
    logic        r_hblank;
    logic        r_vblank;

    t_chan_st    n_ch  [NumTimers];
    logic [15:0] n_tgt [NumTimers];
    logic [2:0]  n_rem;
    logic [1:0]  n_start;
    logic        n_hblank;
    logic        n_vblank;

    logic        w_en  [NumTimers];
    logic        w_run [NumTimers];
    logic [16:0] w_inc [NumTimers];
    t_chan_st    w_adv [NumTimers];
    logic [2:0]  w_irq;
    logic [16:0] w_total;
    t_cmd        w_cmd;

    assign w_cmd   = t_cmd'(i_command);
    assign w_total = {14'd0, r_rem} + {1'b0, i_amount};

    // Run gating from each counter's sync mode.
    always_comb begin
        logic [1:0] sm;
        logic       blank;

        for (int i = 0; i < NumTimers; i++) begin
            sm    = r_ch[i].mode[MB_SYNC_HI:MB_SYNC_LO];
            blank = (i == 0) ? r_hblank : r_vblank;
            w_run[i] = 1'b1;
            if (r_ch[i].mode[MB_SYNC_EN]) begin
                if (i == NumTimers - 1) begin
                    w_run[i] = (sm == SYNC_M1) || (sm == SYNC_M2);
                end else begin
                    case (sm)
                        SYNC_M0: w_run[i] = !blank;
                        SYNC_M2: w_run[i] = blank;
                        SYNC_M3: w_run[i] = r_start[i];
                        default: w_run[i] = 1'b1;
                    endcase
                end
            end
        end
    end

    // Which counters advance this beat, and by how much.
    always_comb begin
        for (int i = 0; i < NumTimers; i++) begin
            w_en[i]  = 1'b0;
            w_inc[i] = '0;
        end
        case (w_cmd)
            CMD_CPU_CYCLES: begin
                w_en[0]  = !r_ch[0].mode[MB_SRC];
                w_inc[0] = {1'b0, i_amount};
                w_en[1]  = !r_ch[1].mode[MB_SRC];
                w_inc[1] = {1'b0, i_amount};
                w_en[2]  = 1'b1;
                w_inc[2] = r_ch[2].mode[MB_DIV8] ? {3'd0, w_total[16:3]} : w_total;
            end
            CMD_DOTS: begin
                w_en[0]  = r_ch[0].mode[MB_SRC];
                w_inc[0] = {1'b0, i_amount};
            end
            CMD_HBLANK_START: begin
                w_en[1]  = r_ch[1].mode[MB_SRC];
                w_inc[1] = 17'd1;
            end
            default: begin
                w_en[0] = 1'b0;
            end
        endcase
    end

    // The three counter advance units.
    for (genvar g = 0; g < NumTimers; g++) begin : g_chan
        tsync_chan u_chan (
            .i_en     (w_en[g]),
            .i_run    (w_run[g]),
            .i_inc    (w_inc[g]),
            .i_target (r_tgt[g]),
            .i_st     (r_ch[g]),
            .o_st     (w_adv[g]),
            .o_irq    (w_irq[g])
        );
    end

    // Blank sync, register access and read data.
    always_comb begin
        logic [1:0] sm0;
        logic [1:0] sm1;

        sm0 = r_ch[0].mode[MB_SYNC_HI:MB_SYNC_LO];
        sm1 = r_ch[1].mode[MB_SYNC_HI:MB_SYNC_LO];
        for (int i = 0; i < NumTimers; i++) begin
            n_ch[i]  = w_adv[i];
            n_tgt[i] = r_tgt[i];
        end
        n_rem       = r_rem;
        n_start     = r_start;
        n_hblank    = r_hblank;
        n_vblank    = r_vblank;
        o_read_data = '0;
        case (w_cmd)
            CMD_CPU_CYCLES: begin
                n_rem = r_ch[2].mode[MB_DIV8] ? w_total[2:0] : 3'd0;
            end
            CMD_HBLANK_START: begin
                n_hblank = 1'b1;
                if (r_ch[0].mode[MB_SYNC_EN]) begin
                    if ((sm0 == SYNC_M1) || (sm0 == SYNC_M2)) begin
                        n_ch[0].count = '0;
                    end else if (sm0 == SYNC_M3) begin
                        n_start[0] = 1'b1;
                    end
                end
            end
            CMD_HBLANK_END: begin
                n_hblank = 1'b0;
            end
            CMD_VBLANK_START: begin
                n_vblank = 1'b1;
                if (r_ch[1].mode[MB_SYNC_EN]) begin
                    if ((sm1 == SYNC_M1) || (sm1 == SYNC_M2)) begin
                        n_ch[1].count = '0;
                    end else if (sm1 == SYNC_M3) begin
                        n_start[1] = 1'b1;
                    end
                end
            end
            CMD_VBLANK_END: begin
                n_vblank = 1'b0;
            end
            CMD_WRITE: begin
                if (i_timer_index <= LAST_TIMER) begin
                    if (i_reg_offset == OFF_COUNT) begin
                        n_ch[i_timer_index].count = {1'b0, i_write_data};
                    end else if (i_reg_offset == OFF_MODE) begin
                        n_ch[i_timer_index].mode  = {3'b001, i_write_data[9:0] & MODE_WRITE_MASK};
                        n_ch[i_timer_index].count = '0;
                        n_ch[i_timer_index].fired = 1'b0;
                        if (i_timer_index != LAST_TIMER) begin
                            n_start[i_timer_index[0]] = 1'b0;
                        end
                    end else if (i_reg_offset == OFF_TARGET) begin
                        n_tgt[i_timer_index] = i_write_data;
                    end
                end
            end
            CMD_READ: begin
                if (i_timer_index <= LAST_TIMER) begin
                    if (i_reg_offset == OFF_COUNT) begin
                        o_read_data = r_ch[i_timer_index].count[15:0];
                    end else if (i_reg_offset == OFF_MODE) begin
                        o_read_data = {3'b000, r_ch[i_timer_index].mode};
                        n_ch[i_timer_index].mode[MB_HIT_TGT] = 1'b0;
                        n_ch[i_timer_index].mode[MB_HIT_MAX] = 1'b0;
                    end else if (i_reg_offset == OFF_TARGET) begin
                        o_read_data = r_tgt[i_timer_index];
                    end
                end
            end
            default: begin
                n_rem = r_rem;
            end
        endcase
    end

    assign o_irq_mask = w_irq;

    // State update on each processed beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumTimers; i++) begin
                r_ch[i]  <= '0;
                r_tgt[i] <= '0;
            end
            r_rem    <= '0;
            r_start  <= '0;
            r_hblank <= 1'b0;
            r_vblank <= 1'b0;
        end else if (i_step) begin
            for (int i = 0; i < NumTimers; i++) begin
                r_ch[i]  <= n_ch[i];
                r_tgt[i] <= n_tgt[i];
            end
            r_rem    <= n_rem;
            r_start  <= n_start;
            r_hblank <= n_hblank;
            r_vblank <= n_vblank;
        end
    end

endmodule

[rtl/three_channel_sync_timer_core.sv]
// Top level of the three-channel synchronized timer: input and result registers.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+------------------------------------------
//   in      | i_in_valid / o_in_ready   | i_command, i_amount, i_timer_index,
//           |                           | i_reg_offset, i_write_data
//   out     | o_out_valid / i_out_ready | o_read_data, o_irq_mask
//
// Each beat is registered at the input, processed combinationally by the three
// counter units, and its result registered at the output.
// One beat per cycle is sustained while the output is not stalled.
// Reset is synchronous and active low and clears all timer state and both valids.
// A stalled output holds its result while the input register keeps one more beat.
module three_channel_sync_timer_core
    import tsync_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_amount,
    input  logic [1:0]  i_timer_index,
    input  logic [3:0]  i_reg_offset,
    input  logic [15:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_read_data,
    output logic [2:0]  o_irq_mask
);

    logic        r_in_valid;
    logic [2:0]  r_command;
    logic [15:0] r_amount;
    logic [1:0]  r_timer_index;
    logic [3:0]  r_reg_offset;
    logic [15:0] r_write_data;

    logic        r_out_valid;
    logic [15:0] r_read_data;
    logic [2:0]  r_irq_mask;

    logic        w_step;
    logic [15:0] w_read_data;
    logic [2:0]  w_irq_mask;

    // A held beat is processed once the result register is free.
    assign w_step      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_step;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_irq_mask  = r_irq_mask;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_command     <= i_command;
            r_amount      <= i_amount;
            r_timer_index <= i_timer_index;
            r_reg_offset  <= i_reg_offset;
            r_write_data  <= i_write_data;
        end
    end

    // Timer state and per-beat update.
    tsync_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_command     (r_command),
        .i_amount      (r_amount),
        .i_timer_index (r_timer_index),
        .i_reg_offset  (r_reg_offset),
        .i_write_data  (r_write_data),
        .o_read_data   (w_read_data),
        .o_irq_mask    (w_irq_mask)
    );

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_read_data <= w_read_data;
            r_irq_mask  <= w_irq_mask;
        end
    end

endmodule

[bench/three_channel_sync_timer_core_tb.sv]
// Self-checking testbench for the three-channel synchronized timer core.
`timescale 1ns / 100ps

module three_channel_sync_timer_core_tb;
    import tsync_pkg::*;

    localparam int RandomBeats  = 1550;
    localparam int CycleLimit   = 200000;
    localparam int SettleCycles = 10;
    localparam int PrintCap     = 100;

    // One input beat and one result beat as the timer sees them.
    typedef struct {
        t_cmd        cmd;
        logic [15:0] amount;
        logic [1:0]  idx;
        logic [3:0]  off;
        logic [15:0] wdata;
        bit          drain;
    } timer_beat_t;

    typedef struct {
        logic [15:0] rdata;
        logic [2:0]  irq;
    } timer_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  cmd_d = '0;
    logic [15:0] amount_d = '0;
    logic [1:0]  idx_d = '0;
    logic [3:0]  off_d = '0;
    logic [15:0] wdata_d = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] o_read_data;
    logic [2:0]  o_irq_mask;

    timer_beat_t   pending_beats[$];
    timer_result_t expected_results[$];
    timer_beat_t   held_beat;
    int            total_beats = 1;
    int            accepted_count = 0;
    int            mismatches = 0;
    int            cycle_count = 0;

    // Predicted timer state.
    logic [16:0] cnt_q   [NumTimers] = '{default: '0};
    logic [12:0] mode_q  [NumTimers] = '{default: '0};
    logic [15:0] tgt_q   [NumTimers] = '{default: '0};
    logic        pend_q  [NumTimers] = '{default: 1'b0};
    logic        fired_q [NumTimers] = '{default: 1'b0};
    logic        start_q [NumTimers] = '{default: 1'b0};
    logic [2:0]  div_rem = '0;
    logic        hblank_q = 1'b0;
    logic        vblank_q = 1'b0;
    logic [2:0]  irq_acc = '0;

    three_channel_sync_timer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (cmd_d),
        .i_amount      (amount_d),
        .i_timer_index (idx_d),
        .i_reg_offset  (off_d),
        .i_write_data  (wdata_d),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_read_data   (o_read_data),
        .o_irq_mask    (o_irq_mask)
    );

    // Clock and a single reset at the start.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PrintCap) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        end
    endtask

    // Idling phase: 0 slow receiver, 1 slow sender, 2 no idling.
    function automatic int idle_phase();
        int p;
        p = (accepted_count * 3) / total_beats;
        return (p > 2) ? 2 : p;
    endfunction

    // Interrupt on wrap: pulse or toggle, once or repeated.
    function automatic void raise_irq(int n);
        if (!mode_q[n][MB_IRQ_EN]) begin
            return;
        end
        if (mode_q[n][MB_TOGGLE]) begin
            if ((mode_q[n][MB_REPEAT] || !fired_q[n]) && mode_q[n][MB_IRQ_LINE]) begin
                mode_q[n][MB_IRQ_LINE] = 1'b0;
                fired_q[n] = 1'b1;
                irq_acc[n] = 1'b1;
            end else if (mode_q[n][MB_REPEAT] && fired_q[n]) begin
                mode_q[n][MB_IRQ_LINE] = 1'b1;
            end
        end else if (mode_q[n][MB_IRQ_LINE]) begin
            mode_q[n][MB_IRQ_LINE] = 1'b0;
            pend_q[n] = 1'b1;
            irq_acc[n] = 1'b1;
        end
    endfunction

    // Advance one counter by inc ticks, honoring its sync mode and wrap point.
    function automatic void advance(int n, int unsigned inc);
        int unsigned sum;
        logic        run;
        logic [1:0]  sm;
        logic        blank;
        run = 1'b1;
        if (pend_q[n]) begin
            mode_q[n][MB_IRQ_LINE] = 1'b1;
            pend_q[n] = 1'b0;
        end
        if (mode_q[n][MB_SYNC_EN]) begin
            sm = mode_q[n][MB_SYNC_HI:MB_SYNC_LO];
            if (n == 2) begin
                run = (sm == SYNC_M1) || (sm == SYNC_M2);
            end else begin
                blank = (n == 0) ? hblank_q : vblank_q;
                case (sm)
                    SYNC_M0: run = !blank;
                    SYNC_M2: run = blank;
                    SYNC_M3: run = start_q[n];
                    default: run = 1'b1;
                endcase
            end
        end
        sum = cnt_q[n];
        if (run) begin
            sum += inc;
        end
        if (mode_q[n][MB_ON_TARGET] && sum >= tgt_q[n]) begin
            sum = 0;
            mode_q[n][MB_HIT_TGT] = 1'b1;
            raise_irq(n);
        end else if (!mode_q[n][MB_ON_TARGET] && sum >= WRAP_LIMIT) begin
            sum = 0;
            mode_q[n][MB_HIT_MAX] = 1'b1;
            raise_irq(n);
        end
        cnt_q[n] = sum[16:0];
    endfunction

    // Blank edge: reset the count or arm the start, per sync mode.
    function automatic void blank_sync(int n);
        logic [1:0] sm;
        sm = mode_q[n][MB_SYNC_HI:MB_SYNC_LO];
        if (mode_q[n][MB_SYNC_EN]) begin
            if (sm == SYNC_M1 || sm == SYNC_M2) begin
                cnt_q[n] = '0;
            end else if (sm == SYNC_M3) begin
                start_q[n] = 1'b1;
            end
        end
    endfunction

    // Apply one beat to the predicted state and return its result.
    function automatic timer_result_t timer_step(timer_beat_t b);
        timer_result_t r;
        int unsigned   total;
        r.rdata = '0;
        irq_acc = '0;
        case (b.cmd)
            CMD_CPU_CYCLES: begin
                if (!mode_q[0][MB_SRC]) advance(0, b.amount);
                if (!mode_q[1][MB_SRC]) advance(1, b.amount);
                total = div_rem + b.amount;
                if (!mode_q[2][MB_DIV8]) begin
                    advance(2, total);
                    div_rem = '0;
                end else begin
                    advance(2, total >> 3);
                    div_rem = total[2:0];
                end
            end
            CMD_DOTS: begin
                if (mode_q[0][MB_SRC]) advance(0, b.amount);
            end
            CMD_HBLANK_START: begin
                hblank_q = 1'b1;
                blank_sync(0);
                if (mode_q[1][MB_SRC]) advance(1, 1);
            end
            CMD_HBLANK_END: hblank_q = 1'b0;
            CMD_VBLANK_START: begin
                vblank_q = 1'b1;
                blank_sync(1);
            end
            CMD_VBLANK_END: vblank_q = 1'b0;
            CMD_WRITE: begin
                if (b.idx <= LAST_TIMER) begin
                    if (b.off == OFF_COUNT) begin
                        cnt_q[b.idx] = {1'b0, b.wdata};
                    end else if (b.off == OFF_MODE) begin
                        mode_q[b.idx] = {3'b001, b.wdata[9:0] & MODE_WRITE_MASK};
                        cnt_q[b.idx] = '0;
                        fired_q[b.idx] = 1'b0;
                        start_q[b.idx] = 1'b0;
                    end else if (b.off == OFF_TARGET) begin
                        tgt_q[b.idx] = b.wdata;
                    end
                end
            end
            default: begin
                if (b.idx <= LAST_TIMER) begin
                    if (b.off == OFF_COUNT) begin
                        r.rdata = cnt_q[b.idx][15:0];
                    end else if (b.off == OFF_MODE) begin
                        r.rdata = {3'b000, mode_q[b.idx]};
                        mode_q[b.idx][MB_HIT_MAX:MB_HIT_TGT] = 2'b00;
                    end else if (b.off == OFF_TARGET) begin
                        r.rdata = tgt_q[b.idx];
                    end
                end
            end
        endcase
        r.irq = irq_acc;
        return r;
    endfunction

    function automatic timer_beat_t make_beat(t_cmd c, logic [15:0] a, logic [1:0] i,
                                              logic [3:0] o, logic [15:0] w);
        timer_beat_t b;
        b.cmd = c;
        b.amount = a;
        b.idx = i;
        b.off = o;
        b.wdata = w;
        b.drain = 1'b0;
        return b;
    endfunction

    // Random beat: mostly meaningful accesses and event counts, some noise.
    function automatic timer_beat_t random_beat();
        timer_beat_t b;
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(0, 99);
        if (roll < 30)      b.cmd = CMD_CPU_CYCLES;
        else if (roll < 40) b.cmd = CMD_DOTS;
        else if (roll < 47) b.cmd = CMD_HBLANK_START;
        else if (roll < 54) b.cmd = CMD_HBLANK_END;
        else if (roll < 59) b.cmd = CMD_VBLANK_START;
        else if (roll < 64) b.cmd = CMD_VBLANK_END;
        else if (roll < 82) b.cmd = CMD_WRITE;
        else                b.cmd = CMD_READ;
        pick = $urandom_range(0, 9);
        if (pick < 5)      b.amount = 16'($urandom_range(0, 31));
        else if (pick < 8) b.amount = 16'($urandom_range(0, 1023));
        else               b.amount = 16'($urandom);
        b.idx = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        pick = $urandom_range(0, 7);
        if (pick == 0)      b.off = 4'($urandom);
        else if (pick < 3)  b.off = OFF_COUNT;
        else if (pick < 6)  b.off = OFF_MODE;
        else                b.off = OFF_TARGET;
        b.wdata = 16'($urandom);
        if (b.cmd == CMD_WRITE && b.off == OFF_TARGET && $urandom_range(0, 1) == 0) begin
            b.wdata = 16'($urandom_range(0, 255));
        end
        b.drain = 1'b0;
        return b;
    endfunction

    // Driver: present queued beats, predicting each one as it is accepted.
    always @(posedge i_clk) begin : drive_proc
        logic fire;
        logic load;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            cycle_count++;
            fire = in_valid && o_in_ready;
            if (fire) begin
                expected_results.push_back(timer_step(held_beat));
                accepted_count++;
            end
            if (!in_valid || fire) begin
                load = (pending_beats.size() != 0);
                if (idle_phase() == 0 && $urandom_range(0, 99) < 25) load = 1'b0;
                if (idle_phase() == 1 && $urandom_range(0, 99) < 65) load = 1'b0;
                // Hold off a marked beat until every earlier result is back.
                if (load && pending_beats[0].drain && expected_results.size() != 0) begin
                    load = 1'b0;
                end
                if (load) begin
                    held_beat = pending_beats.pop_front();
                    cmd_d    <= held_beat.cmd;
                    amount_d <= held_beat.amount;
                    idx_d    <= held_beat.idx;
                    off_d    <= held_beat.off;
                    wdata_d  <= held_beat.wdata;
                end
                in_valid <= load;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin : monitor_proc
        timer_result_t want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with no prediction waiting");
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.rdata) begin
                    report_mismatch($sformatf("read_data got %h want %h",
                                              o_read_data, want.rdata));
                end
                if (o_irq_mask !== want.irq) begin
                    report_mismatch($sformatf("irq_mask got %b want %b",
                                              o_irq_mask, want.irq));
                end
            end
        end
        case (idle_phase())
            0:       out_ready <= ($urandom_range(0, 99) >= 65);
            1:       out_ready <= ($urandom_range(0, 99) >= 25);
            default: out_ready <= 1'b1;
        endcase
    end

    // Stimulus and end of run.
    initial begin : stim_proc
        timer_beat_t b;
        // Reset values, then a wrap at the target with a pulsed interrupt.
        pending_beats.push_back(make_beat(CMD_READ, 16'h0000, 2'd0, OFF_MODE, 16'h0000));
        pending_beats.push_back(make_beat(CMD_WRITE, 16'hFFFF, 2'd0, OFF_TARGET, 16'hFFFF));
        pending_beats.push_back(make_beat(CMD_WRITE, 16'h0000, 2'd0, OFF_MODE, 16'h0058));
        pending_beats.push_back(make_beat(CMD_WRITE, 16'h0000, 2'd0, OFF_COUNT, 16'hFFFE));
        pending_beats.push_back(make_beat(CMD_CPU_CYCLES, 16'hFFFF, 2'd0, OFF_COUNT, 16'h0));
        // Reading the mode shows the sticky flag once, then clears it.
        pending_beats.push_back(make_beat(CMD_READ, 16'h0000, 2'd0, OFF_MODE, 16'h0000));
        pending_beats.push_back(make_beat(CMD_READ, 16'h0000, 2'd0, OFF_MODE, 16'h0000));
        // Counter 2 on the divided clock with repeated toggle interrupts.
        pending_beats.push_back(make_beat(CMD_WRITE, 16'h0000, 2'd2, OFF_MODE, 16'h02D0));
        pending_beats.push_back(make_beat(CMD_CPU_CYCLES, 16'h0007, 2'd0, OFF_COUNT, 16'h0));
        pending_beats.push_back(make_beat(CMD_CPU_CYCLES, 16'h0001, 2'd0, OFF_COUNT, 16'h0));
        // Counter 1 counts hblanks but waits for a vblank to start.
        pending_beats.push_back(make_beat(CMD_WRITE, 16'h0000, 2'd1, OFF_MODE, 16'h0107));
        pending_beats.push_back(make_beat(CMD_HBLANK_START, 16'h0, 2'd0, OFF_COUNT, 16'h0));
        pending_beats.push_back(make_beat(CMD_VBLANK_START, 16'h0, 2'd0, OFF_COUNT, 16'h0));
        pending_beats.push_back(make_beat(CMD_HBLANK_START, 16'h0, 2'd0, OFF_COUNT, 16'h0));
        pending_beats.push_back(make_beat(CMD_READ, 16'h0000, 2'd1, OFF_COUNT, 16'h0000));
        pending_beats.push_back(make_beat(CMD_VBLANK_END, 16'h0, 2'd0, OFF_COUNT, 16'h0));
        pending_beats.push_back(make_beat(CMD_HBLANK_END, 16'h0, 2'd0, OFF_COUNT, 16'h0));
        // A bad counter index and a bad offset are ignored.
        pending_beats.push_back(make_beat(CMD_WRITE, 16'h0000, 2'd3, OFF_COUNT, 16'h1234));
        pending_beats.push_back(make_beat(CMD_READ, 16'h0000, 2'd3, OFF_MODE, 16'h0000));
        pending_beats.push_back(make_beat(CMD_READ, 16'h0000, 2'd0, 4'd2, 16'h0000));
        // All writable mode bits on, and counter 0 fed a full dot count.
        pending_beats.push_back(make_beat(CMD_WRITE, 16'h0000, 2'd0, OFF_MODE, 16'hFFFF));
        pending_beats.push_back(make_beat(CMD_DOTS, 16'hFFFF, 2'd0, OFF_COUNT, 16'h0));
        pending_beats.push_back(make_beat(CMD_READ, 16'h0000, 2'd2, OFF_TARGET, 16'h0000));
        // Counter 2 stopped by its sync mode.
        pending_beats.push_back(make_beat(CMD_WRITE, 16'h0000, 2'd2, OFF_MODE, 16'h0001));
        pending_beats.push_back(make_beat(CMD_CPU_CYCLES, 16'h0064, 2'd0, OFF_COUNT, 16'h0));
        pending_beats.push_back(make_beat(CMD_READ, 16'h0000, 2'd2, OFF_COUNT, 16'h0000));

        for (int n = 0; n < RandomBeats; n++) begin
            b = random_beat();
            b.drain = (n % 500 == 250);
            pending_beats.push_back(b);
        end
        total_beats = pending_beats.size();

        // Run until every beat is accepted and every result is back.
        while ((accepted_count != total_beats || expected_results.size() != 0)
               && cycle_count < CycleLimit) begin
            @(posedge i_clk);
        end
        if (cycle_count >= CycleLimit) begin
            $display("== FAIL ==");
        end else begin
            repeat (SettleCycles) @(posedge i_clk);
            if (expected_results.size() != 0) begin
                report_mismatch($sformatf("%0d predicted results never arrived",
                                          expected_results.size()));
            end
            if (mismatches == 0) begin
                $display("== PASS ==");
            end else begin
                $display("== FAIL ==");
            end
        end
        $finish;
    end

endmodule
